// ===== src/hcbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman code bit packer package
// Shared sizes, function codes and the types passed between the front end,
// the operation queue and the packing back end.
// ----------------------------------------------------------------------------
package hcbp_pkg;

    // Sizes of the packed word, the codes and the code table.
    localparam int WORD_BITS    = 64;
    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOL_COUNT = 256;

    // Field widths.
    localparam int SYM_W  = 8;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int CNT_W  = 7;
    localparam int FUNC_W = 2;

    // Operation queue between front end and back end.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 3;

    // Result queue inside the back end.
    localparam int RQ_DEPTH = 2;
    localparam int RQ_PTR_W = 1;
    localparam int RQ_CNT_W = 2;

    // Input function codes.
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ENCODE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd2;

    // Kinds of operation handed to the back end.
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // One classified operation for the back end.
    typedef struct packed {
        logic              kind;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_op;

    // Fill status of the operation queue, seen by the front end.
    typedef struct packed {
        logic [OQ_CNT_W-1:0] count;
    } t_q_stat;

    // One result beat.
    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [CNT_W-1:0]     bits;
        logic                 final_flag;
    } t_res;

endpackage

// ===== src/hcbp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman code bit packer front end
// Accepts input beats, owns the code table, looks up encode symbols and
// hands encode and flush operations to the operation queue.
// ----------------------------------------------------------------------------
module hcbp_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [hcbp_pkg::FUNC_W-1:0]      i_func,
    input  logic [hcbp_pkg::SYM_W-1:0]       i_symbol,
    input  logic [hcbp_pkg::CODE_W-1:0]      i_code_value,
    input  logic [hcbp_pkg::LEN_W-1:0]       i_code_length,
    input  hcbp_pkg::t_q_stat                i_q_stat,
    output logic                             o_op_push,
    output hcbp_pkg::t_op                    o_op
);

    localparam int ENTRY_W = hcbp_pkg::CODE_W + hcbp_pkg::LEN_W;

    // Code table: length in the low bits, code bits above.
    logic [ENTRY_W-1:0]                r_table [hcbp_pkg::SYMBOL_COUNT];
    logic [hcbp_pkg::SYMBOL_COUNT-1:0] r_table_vld;

    logic [ENTRY_W-1:0]                r_rd_entry;
    logic                              r_rd_vld;
    logic                              r_s1_vld;
    logic [hcbp_pkg::FUNC_W-1:0]       r_s1_func;

    logic                              w_accept;
    logic                              w_load;
    logic [hcbp_pkg::LEN_W-1:0]        w_load_len;
    logic [hcbp_pkg::CODE_W:0]         w_load_mask;
    logic [hcbp_pkg::LEN_W-1:0]        w_entry_len;
    logic                              n_s1_vld;

    // Room is needed for the beat in the lookup stage and the new one.
    always_comb begin
        if (r_s1_vld) begin
            full = (i_q_stat.count >= hcbp_pkg::OQ_CNT_W'(hcbp_pkg::OQ_DEPTH - 1));
        end else begin
            full = (i_q_stat.count >= hcbp_pkg::OQ_CNT_W'(hcbp_pkg::OQ_DEPTH));
        end
    end

    assign w_accept = push && !full;
    assign w_load   = w_accept && (i_func == hcbp_pkg::FUNC_LOAD);

    // Saturate the loaded length and drop code bits above it.
    always_comb begin
        if (i_code_length > hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN)) begin
            w_load_len = hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN);
        end else begin
            w_load_len = i_code_length;
        end
        w_load_mask = ((hcbp_pkg::CODE_W + 1)'(1) << w_load_len) - 1'b1;
    end

    // Table write and registered lookup.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_table[i_symbol] <= {i_code_value & w_load_mask[hcbp_pkg::CODE_W-1:0],
                                  w_load_len};
        end
        if (w_accept) begin
            r_rd_entry <= r_table[i_symbol];
        end
    end

    // Entry valid bits; an entry never loaded reads as zero length.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_vld <= '0;
            r_rd_vld    <= 1'b0;
        end else begin
            if (w_load) begin
                r_table_vld[i_symbol] <= 1'b1;
            end
            if (w_accept) begin
                r_rd_vld <= r_table_vld[i_symbol];
            end
        end
    end

    // Lookup stage control: only encode and flush beats go further.
    assign n_s1_vld = w_accept &&
                      ((i_func == hcbp_pkg::FUNC_ENCODE) || (i_func == hcbp_pkg::FUNC_FLUSH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s1_func <= hcbp_pkg::FUNC_LOAD;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_s1_func <= i_func;
        end
    end

    // Classify: encodes of empty entries are dropped here.
    assign w_entry_len = r_rd_vld ? r_rd_entry[hcbp_pkg::LEN_W-1:0] : '0;

    always_comb begin
        o_op.kind = (r_s1_func == hcbp_pkg::FUNC_FLUSH) ? hcbp_pkg::OP_FLUSH
                                                        : hcbp_pkg::OP_ENCODE;
        o_op.code = r_rd_vld ? r_rd_entry[ENTRY_W-1:hcbp_pkg::LEN_W] : '0;
        o_op.len  = w_entry_len;
        o_op_push = r_s1_vld &&
                    ((r_s1_func == hcbp_pkg::FUNC_FLUSH) || (w_entry_len != '0));
    end

endmodule

// ===== src/hcbp_op_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman code bit packer operation queue
// Short first-in first-out queue that decouples the front end from the
// packing back end.
// ----------------------------------------------------------------------------
module hcbp_op_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hcbp_pkg::t_op     i_op,
    input  logic              i_pop,
    output hcbp_pkg::t_op     o_op,
    output logic              o_empty,
    output hcbp_pkg::t_q_stat o_stat
);

    hcbp_pkg::t_op                 r_mem [hcbp_pkg::OQ_DEPTH];
    logic [hcbp_pkg::OQ_PTR_W-1:0] r_wr_ptr;
    logic [hcbp_pkg::OQ_PTR_W-1:0] r_rd_ptr;
    logic [hcbp_pkg::OQ_CNT_W-1:0] r_count;
    logic                          w_pop;

    assign o_empty      = (r_count == '0);
    assign o_op         = r_mem[r_rd_ptr];
    assign o_stat.count = r_count;
    assign w_pop        = i_pop && !o_empty;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // The front end must never push into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < hcbp_pkg::OQ_CNT_W'(hcbp_pkg::OQ_DEPTH)))
        else $error("operation queue overflow");

endmodule

// ===== src/hcbp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman code bit packer back end
// Appends code bits to the pending buffer, forms full and flush words and
// holds them in a small result queue until they are popped.
// ----------------------------------------------------------------------------
module hcbp_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  hcbp_pkg::t_op                     i_op,
    input  logic                              i_op_empty,
    output logic                              o_op_pop,
    input  logic                              pop,
    output logic                              empty,
    output logic [hcbp_pkg::WORD_BITS-1:0]    o_packed_word,
    output logic [hcbp_pkg::CNT_W-1:0]        o_word_bits,
    output logic                              o_final_word
);

    localparam int W = hcbp_pkg::WORD_BITS;
    localparam int C = hcbp_pkg::CNT_W;

    // Pending bit buffer, right-aligned.
    logic [W-1:0]                  r_pend;
    logic [C-1:0]                  r_cnt;
    logic [W-1:0]                  n_pend;
    logic [C-1:0]                  n_cnt;

    // Result queue.
    hcbp_pkg::t_res                r_res [hcbp_pkg::RQ_DEPTH];
    logic [hcbp_pkg::RQ_PTR_W-1:0] r_wr_ptr;
    logic [hcbp_pkg::RQ_PTR_W-1:0] r_rd_ptr;
    logic [hcbp_pkg::RQ_CNT_W-1:0] r_oc;

    logic                          w_take;
    logic                          w_res_vld;
    hcbp_pkg::t_res                w_res;
    logic                          w_out_pop;
    logic [C-1:0]                  w_sum;
    logic [C-1:0]                  w_take_bits;
    logic [C-1:0]                  w_rest;
    logic                          w_wrap;
    logic [W-1:0]                  w_code;
    logic [W-1:0]                  w_rest_mask;

    // Take an operation whenever a result slot is free.
    assign w_take   = !i_op_empty && (r_oc != hcbp_pkg::RQ_CNT_W'(hcbp_pkg::RQ_DEPTH));
    assign o_op_pop = w_take;

    // Append arithmetic.
    always_comb begin
        w_code      = W'(i_op.code);
        w_sum       = r_cnt + C'(i_op.len);
        w_wrap      = (w_sum >= C'(W));
        w_take_bits = C'(W) - r_cnt;
        w_rest      = w_sum - C'(W);
        w_rest_mask = (W'(1) << w_rest) - 1'b1;
    end

    // Next buffer state and result for the operation at the queue head.
    always_comb begin
        n_pend           = r_pend;
        n_cnt            = r_cnt;
        w_res_vld        = 1'b0;
        w_res.word       = r_pend;
        w_res.bits       = r_cnt;
        w_res.final_flag = 1'b1;
        if (w_take) begin
            if (i_op.kind == hcbp_pkg::OP_FLUSH) begin
                w_res_vld = (r_cnt != '0);
                n_pend    = '0;
                n_cnt     = '0;
            end else if (w_wrap) begin
                w_res_vld        = 1'b1;
                w_res.word       = (r_pend << w_take_bits) | (w_code >> w_rest);
                w_res.bits       = C'(W);
                w_res.final_flag = 1'b0;
                n_pend           = w_code & w_rest_mask;
                n_cnt            = w_rest;
            end else begin
                n_pend = (r_pend << i_op.len) | w_code;
                n_cnt  = w_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_cnt  <= '0;
        end else begin
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
        end
    end

    // Result queue storage and control.
    assign w_out_pop     = pop && !empty;
    assign empty         = (r_oc == '0);
    assign o_packed_word = r_res[r_rd_ptr].word;
    assign o_word_bits   = r_res[r_rd_ptr].bits;
    assign o_final_word  = r_res[r_rd_ptr].final_flag;

    always_ff @(posedge i_clk) begin
        if (w_res_vld) begin
            r_res[r_wr_ptr] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_oc     <= '0;
        end else begin
            if (w_res_vld) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_out_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_res_vld, w_out_pop})
                2'b10:   r_oc <= r_oc + 1'b1;
                2'b01:   r_oc <= r_oc - 1'b1;
                default: r_oc <= r_oc;
            endcase
        end
    end

    // The pending buffer never holds a whole word.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < C'(W))
        else $error("pending count reached a full word");

    // A consumed flush leaves the buffer empty.
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && (i_op.kind == hcbp_pkg::OP_FLUSH)) |=> (r_cnt == '0))
        else $error("flush did not empty the pending buffer");

    // A full word always carries the whole word count and no final mark.
    a_full_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_vld && !w_res.final_flag) |-> (w_res.bits == C'(W)))
        else $error("full word with a short bit count");

endmodule

// ===== src/huffman_code_bit_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman code bit packer
// Table-driven Huffman encoder that packs code bits into 64-bit words.
// ----------------------------------------------------------------------------
// The block takes one beat per clock while full is low: load beats write a
// symbol's code and length into a 256-entry table, encode beats append the
// symbol's code (most significant code bit first) to a pending buffer, and a
// flush beat emits the leftover bits right-aligned with their count. A full
// word reaches the result side through the registered table read, the
// operation queue and the packing unit that writes the result queue. The
// table read and the shift-and-merge in the packing unit set the rate of one
// beat per cycle; full holds beats off when the operation queue fills. The
// table's entry valid bits clear together at reset, so no beat is held off
// after reset. Unloaded or zero-length symbols add nothing.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [hcbp_pkg::FUNC_W-1:0]          i_func,
    input  logic [hcbp_pkg::SYM_W-1:0]           i_symbol,
    input  logic [hcbp_pkg::CODE_W-1:0]          i_code_value,
    input  logic [hcbp_pkg::LEN_W-1:0]           i_code_length,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [hcbp_pkg::WORD_BITS-1:0]       o_packed_word,
    output logic [hcbp_pkg::CNT_W-1:0]           o_word_bits,
    output logic                                 o_final_word
);

    hcbp_pkg::t_q_stat w_q_stat;
    hcbp_pkg::t_op     w_push_op;
    hcbp_pkg::t_op     w_head_op;
    logic              w_op_push;
    logic              w_op_pop;
    logic              w_op_empty;

    // Front end: table and lookup.
    hcbp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_func        (i_func),
        .i_symbol      (i_symbol),
        .i_code_value  (i_code_value),
        .i_code_length (i_code_length),
        .i_q_stat      (w_q_stat),
        .o_op_push     (w_op_push),
        .o_op          (w_push_op)
    );

    // Operation queue between the two sides.
    hcbp_op_queue u_op_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_op_push),
        .i_op    (w_push_op),
        .i_pop   (w_op_pop),
        .o_op    (w_head_op),
        .o_empty (w_op_empty),
        .o_stat  (w_q_stat)
    );

    // Back end: bit packing and result queue.
    hcbp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (w_head_op),
        .i_op_empty    (w_op_empty),
        .o_op_pop      (w_op_pop),
        .pop           (pop),
        .empty         (empty),
        .o_packed_word (o_packed_word),
        .o_word_bits   (o_word_bits),
        .o_final_word  (o_final_word)
    );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the Huffman code bit packer
// A short table of directed beats (table loads, saturated and zero lengths,
// exact and split word boundaries, empty and partial flushes, the unused
// function code) is followed by a full random table load and a long random
// mix of loads, encodes, flushes and unused beats. Each accepted beat runs
// through a bit-accurate packing predictor, and every popped word is checked
// field by field against the oldest predicted word. Both sides idle at
// random, and once the reader stops popping long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_top;
    import hcbp_pkg::*;

    // Function code that the block ignores.
    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

    localparam int RANDOM_BEATS   = 1050;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 32;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int MAX_REPORTS    = 10;

    // How a directed row is checked.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_WORD
    } chk_e;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] code_value;
        logic [LEN_W-1:0]  code_length;
        chk_e              chk;
        t_res              want;
    } beat_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 push;
    logic                 full;
    logic [FUNC_W-1:0]    i_func;
    logic [SYM_W-1:0]     i_symbol;
    logic [CODE_W-1:0]    i_code_value;
    logic [LEN_W-1:0]     i_code_length;
    logic                 empty;
    logic                 pop;
    logic [WORD_BITS-1:0] o_packed_word;
    logic [CNT_W-1:0]     o_word_bits;
    logic                 o_final_word;

    // Predictor state: the code table and the bits not yet packed.
    logic [CODE_W-1:0]    tbl_code [SYMBOL_COUNT];
    int                   tbl_len  [SYMBOL_COUNT];
    logic [WORD_BITS-1:0] pend_bits;
    int                   pend_cnt;

    t_res  words_due [$];
    beat_t dir_rows  [$];
    int    mismatches;
    int    cycle_count;
    bit    tx_calm;
    bit    hold_go;

    huffman_code_bit_packer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_func        (i_func),
        .i_symbol      (i_symbol),
        .i_code_value  (i_code_value),
        .i_code_length (i_code_length),
        .empty         (empty),
        .pop           (pop),
        .o_packed_word (o_packed_word),
        .o_word_bits   (o_word_bits),
        .o_final_word  (o_final_word)
    );

    // Free-running clock, 4 ns period.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Cycle counter and run limit.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    function automatic logic [WORD_BITS-1:0] low_bits(input int n);
        if (n >= WORD_BITS) return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    // Applies one beat to the predictor; returns 1 when the beat completes or flushes a word.
    function automatic bit pack_code_beat(input logic [FUNC_W-1:0] fn,
                                          input logic [SYM_W-1:0] sym,
                                          input logic [CODE_W-1:0] cv,
                                          input logic [LEN_W-1:0] cl,
                                          output t_res word);
        int                   len;
        int                   take;
        int                   rest;
        logic [WORD_BITS-1:0] code;
        word = '0;
        case (fn)
            FUNC_LOAD: begin
                // Lengths above the code limit saturate; extra code bits drop.
                len = (cl > MAX_CODE_LEN) ? MAX_CODE_LEN : int'(cl);
                tbl_len[sym]  = len;
                tbl_code[sym] = CODE_W'(cv & low_bits(len));
                return 1'b0;
            end
            FUNC_ENCODE: begin
                len  = tbl_len[sym];
                code = WORD_BITS'(tbl_code[sym]);
                if (len == 0) return 1'b0;
                if (pend_cnt + len >= WORD_BITS) begin
                    // The code straddles the word boundary: top part closes
                    // the word, the rest stays pending.
                    take = WORD_BITS - pend_cnt;
                    rest = len - take;
                    word.word       = (pend_bits << take) | (code >> rest);
                    word.bits       = CNT_W'(WORD_BITS);
                    word.final_flag = 1'b0;
                    pend_bits = code & low_bits(rest);
                    pend_cnt  = rest;
                    return 1'b1;
                end
                pend_bits = (pend_bits << len) | code;
                pend_cnt  = pend_cnt + len;
                return 1'b0;
            end
            FUNC_FLUSH: begin
                if (pend_cnt == 0) return 1'b0;
                word.word       = pend_bits & low_bits(pend_cnt);
                word.bits       = CNT_W'(pend_cnt);
                word.final_flag = 1'b1;
                pend_bits = '0;
                pend_cnt  = 0;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Idle gap length: mostly none, some short, a few long.
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(99, 0);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Code lengths lean short, with some zero and some overlong ones.
    function automatic logic [LEN_W-1:0] pick_code_len();
        int r;
        r = $urandom_range(99, 0);
        if (r < 6) return '0;
        if (r < 12) return LEN_W'($urandom_range(63, MAX_CODE_LEN + 1));
        if (r < 60) return LEN_W'($urandom_range(12, 1));
        return LEN_W'($urandom_range(MAX_CODE_LEN, 13));
    endfunction

    function automatic beat_t random_beat(input logic [FUNC_W-1:0] fn);
        beat_t b;
        b.func        = fn;
        b.sym         = SYM_W'($urandom_range(SYMBOL_COUNT - 1, 0));
        b.code_value  = $urandom();
        b.code_length = pick_code_len();
        b.chk         = CHK_MODEL;
        b.want        = '0;
        return b;
    endfunction

    task automatic add_row(input logic [FUNC_W-1:0] fn, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] cv, input logic [LEN_W-1:0] cl,
                           input chk_e chk, input logic [WORD_BITS-1:0] w,
                           input logic [CNT_W-1:0] nbits, input logic fin);
        beat_t b;
        b.func            = fn;
        b.sym             = sym;
        b.code_value      = cv;
        b.code_length     = cl;
        b.chk             = chk;
        b.want.word       = w;
        b.want.bits       = nbits;
        b.want.final_flag = fin;
        dir_rows.push_back(b);
    endtask

    // Offers one beat after a random gap and records what it should produce.
    task automatic send_beat(input beat_t b);
        int   gap;
        bit   has_word;
        t_res w;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        push          <= 1'b1;
        i_func        <= b.func;
        i_symbol      <= b.sym;
        i_code_value  <= b.code_value;
        i_code_length <= b.code_length;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        // The predictor always runs so its state tracks the block.
        has_word = pack_code_beat(b.func, b.sym, b.code_value, b.code_length, w);
        case (b.chk)
            CHK_MODEL: if (has_word) words_due.push_back(w);
            CHK_WORD:  words_due.push_back(b.want);
            default: ;
        endcase
    endtask

    task automatic note_mismatch(input string what, input t_res want, input t_res got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s: expected word %h bits %0d final %0b, got word %h bits %0d final %0b",
                     $time, what, want.word, want.bits, want.final_flag,
                     got.word, got.bits, got.final_flag);
    endtask

    // Result side: compare every popped beat with the oldest expected word.
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n && pop && empty === 1'b0) begin
            got.word       = o_packed_word;
            got.bits       = o_word_bits;
            got.final_flag = o_final_word;
            if (words_due.size() == 0) begin
                note_mismatch("word with none expected", '0, got);
            end else begin
                want = words_due.pop_front();
                if (got.word !== want.word || got.bits !== want.bits
                        || got.final_flag !== want.final_flag)
                    note_mismatch("word mismatch", want, got);
            end
        end
    end

    // Reader: random pop gaps, calm stretches, and one long hold-off.
    initial begin : rx_side
        int idle_left;
        int hold_left;
        bit hold_taken;
        idle_left  = 0;
        hold_left  = 0;
        hold_taken = 1'b0;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                idle_left = pick_gap(((cycle_count / 300) % 4) == 2);
            end
        end
    end

    // Writer: reset, directed table, full table load, then the random mix.
    initial begin : tx_side
        int    n;
        int    r;
        beat_t b;
        logic [FUNC_W-1:0] fn;
        mismatches    = 0;
        tx_calm       = 1'b0;
        hold_go       = 1'b0;
        pend_bits     = '0;
        pend_cnt      = 0;
        i_rst_n       = 1'b0;
        push          = 1'b0;
        i_func        = FUNC_LOAD;
        i_symbol      = '0;
        i_code_value  = '0;
        i_code_length = '0;
        for (n = 0; n < SYMBOL_COUNT; n++) begin
            tbl_code[n] = '0;
            tbl_len[n]  = 0;
        end

        // Unloaded symbol, empty flush and unused code right after reset.
        add_row(FUNC_ENCODE, 8'd0, 32'h0, 6'd0, CHK_NONE, '0, '0, 1'b0);
        add_row(FUNC_FLUSH, 8'd0, 32'h0, 6'd0, CHK_NONE, '0, '0, 1'b0);
        add_row(FUNC_NONE, 8'hA5, 32'hDEADBEEF, 6'h2A, CHK_NONE, '0, '0, 1'b0);
        // Longest code, saturated length, dropped extra bits, zero length.
        add_row(FUNC_LOAD, 8'd255, 32'hFFFFFFFF, 6'd32, CHK_NONE, '0, '0, 1'b0);
        add_row(FUNC_LOAD, 8'd0, 32'hFFFFFFFF, 6'd63, CHK_NONE, '0, '0, 1'b0);
        add_row(FUNC_LOAD, 8'd1, 32'hFFFFFFFF, 6'd1, CHK_NONE, '0, '0, 1'b0);
        add_row(FUNC_LOAD, 8'd2, 32'hFFFFFFFF, 6'd0, CHK_NONE, '0, '0, 1'b0);
        add_row(FUNC_LOAD, 8'd3, 32'h00000000, 6'd32, CHK_NONE, '0, '0, 1'b0);
        add_row(FUNC_ENCODE, 8'd2, 32'h0, 6'd0, CHK_NONE, '0, '0, 1'b0);
        // Two 32-bit codes fill one word exactly.
        add_row(FUNC_ENCODE, 8'd255, 32'h0, 6'd0, CHK_NONE, '0, '0, 1'b0);
        add_row(FUNC_ENCODE, 8'd3, 32'h0, 6'd0, CHK_WORD,
                64'hFFFFFFFF_00000000, 7'd64, 1'b0);
        // A single leftover bit comes out right-aligned on flush.
        add_row(FUNC_ENCODE, 8'd1, 32'h0, 6'd0, CHK_NONE, '0, '0, 1'b0);
        add_row(FUNC_FLUSH, 8'd0, 32'h0, 6'd0, CHK_WORD, 64'h1, 7'd1, 1'b1);
        add_row(FUNC_ENCODE, 8'd0, 32'h0, 6'd0, CHK_NONE, '0, '0, 1'b0);
        add_row(FUNC_ENCODE, 8'd255, 32'h0, 6'd0, CHK_WORD, '1, 7'd64, 1'b0);
        add_row(FUNC_FLUSH, 8'd0, 32'h0, 6'd0, CHK_NONE, '0, '0, 1'b0);
        // A code split across the word boundary, then its tail flushed.
        add_row(FUNC_LOAD, 8'd4, 32'h5, 6'd3, CHK_NONE, '0, '0, 1'b0);
        add_row(FUNC_LOAD, 8'd5, 32'hF0F0F0F0, 6'd33, CHK_NONE, '0, '0, 1'b0);
        add_row(FUNC_ENCODE, 8'd4, 32'h0, 6'd0, CHK_MODEL, '0, '0, 1'b0);
        add_row(FUNC_ENCODE, 8'd255, 32'h0, 6'd0, CHK_MODEL, '0, '0, 1'b0);
        add_row(FUNC_ENCODE, 8'd5, 32'h0, 6'd0, CHK_MODEL, '0, '0, 1'b0);
        add_row(FUNC_FLUSH, 8'd0, 32'h0, 6'd0, CHK_MODEL, '0, '0, 1'b0);
        // Reloading an entry with zero length silences it.
        add_row(FUNC_LOAD, 8'd255, 32'hFFFFFFFF, 6'd0, CHK_NONE, '0, '0, 1'b0);
        add_row(FUNC_ENCODE, 8'd255, 32'h0, 6'd0, CHK_NONE, '0, '0, 1'b0);
        add_row(FUNC_ENCODE, 8'd1, 32'h0, 6'd0, CHK_MODEL, '0, '0, 1'b0);
        add_row(FUNC_FLUSH, 8'd0, 32'h0, 6'd0, CHK_WORD, 64'h1, 7'd1, 1'b1);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) send_beat(dir_rows[i]);

        // Load every table entry with random content.
        for (n = 0; n < SYMBOL_COUNT; n++) begin
            b = random_beat(FUNC_LOAD);
            b.sym = SYM_W'(n);
            send_beat(b);
        end

        // Random mix, mostly encodes; the reader holds off once at the start.
        hold_go = 1'b1;
        for (n = 0; n < RANDOM_BEATS; n++) begin
            tx_calm = ((n / 100) % 4) == 1;
            r = $urandom_range(99, 0);
            if (r < 10)      fn = FUNC_LOAD;
            else if (r < 88) fn = FUNC_ENCODE;
            else if (r < 97) fn = FUNC_FLUSH;
            else             fn = FUNC_NONE;
            send_beat(random_beat(fn));
        end
        @(negedge i_clk);
        push <= 1'b0;

        while (words_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && words_due.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
